// ----- src/sebx_pkg.sv -----
package sebx_pkg;

    localparam int GAP_W = 16;
    localparam int BYTE_W = 8;
    localparam int POS_W = 4;

    localparam logic [GAP_W-1:0] GAP_RESET = 16'd1500;

    // Edge kinds carried in cmd
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DRIVE  = 1'b1;

    // Frame positions (position number plus three)
    localparam logic [POS_W-1:0] POS_IDLE    = 4'd12;
    localparam logic [POS_W-1:0] POS_START   = 4'd11;
    localparam logic [POS_W-1:0] POS_DATA_HI = 4'd10;
    localparam logic [POS_W-1:0] POS_DATA_LO = 4'd3;
    localparam logic [POS_W-1:0] POS_PARITY  = 4'd2;
    localparam logic [POS_W-1:0] POS_REPORT  = 4'd1;
    localparam logic [POS_W-1:0] POS_STOP    = 4'd0;

    typedef struct packed {
        logic              cmd;
        logic              line_in;
        logic [GAP_W-1:0]  gap_us;
        logic [BYTE_W-1:0] tx_byte;
    } item_t;

    typedef struct packed {
        logic              line_out;
        logic              tx_taken;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_fault;
        logic              parity_fault;
        logic              remote_fault;
    } result_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic              frame_flag;
        logic              local_par_flag;
        logic              remote_par_flag;
        logic              send_par;
        logic              recv_par;
        logic [BYTE_W-1:0] rx_shift;
        logic [BYTE_W-1:0] tx_hold;
    } link_state_t;

endpackage

// ----- src/sebx_if.sv -----
interface sebx_item_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic                        line_in;
    logic [sebx_pkg::GAP_W-1:0]  gap_us;
    logic [sebx_pkg::BYTE_W-1:0] tx_byte;

    modport source (output valid, output cmd, output line_in, output gap_us,
                    output tx_byte, input ready);
    modport sink (input valid, input cmd, input line_in, input gap_us,
                  input tx_byte, output ready);
endinterface

interface sebx_result_if;
    logic                        valid;
    logic                        ready;
    logic                        line_out;
    logic                        tx_taken;
    logic                        rx_valid;
    logic [sebx_pkg::BYTE_W-1:0] rx_byte;
    logic                        frame_fault;
    logic                        parity_fault;
    logic                        remote_fault;

    modport source (output valid, output line_out, output tx_taken, output rx_valid,
                    output rx_byte, output frame_fault, output parity_fault,
                    output remote_fault, input ready);
    modport sink (input valid, input line_out, input tx_taken, input rx_valid,
                  input rx_byte, input frame_fault, input parity_fault,
                  input remote_fault, output ready);
endinterface

// ----- src/sebx_step.sv -----
module sebx_step (
    input  sebx_pkg::link_state_t          st,
    input  sebx_pkg::item_t                it,
    input  logic [sebx_pkg::GAP_W-1:0]     gap_thr,
    output sebx_pkg::link_state_t          st_next,
    output sebx_pkg::result_t              res
);

    logic [sebx_pkg::POS_W-1:0] pos_w;
    logic [sebx_pkg::POS_W-1:0] data_off;
    logic [sebx_pkg::POS_W-1:0] drv_off;
    logic                       line;

    assign data_off = st.pos - sebx_pkg::POS_DATA_LO;

    always_comb
    begin
        st_next = st;
        res     = '0;
        pos_w   = st.pos;
        drv_off = '0;
        line    = 1'b0;
        unique case (it.cmd)
            sebx_pkg::CMD_SAMPLE:
            begin
                priority if (st.pos == sebx_pkg::POS_START)
                begin
                    if (it.line_in)
                        st_next.frame_flag = 1'b1;
                end
                else if (st.pos >= sebx_pkg::POS_DATA_LO && st.pos <= sebx_pkg::POS_DATA_HI)
                begin
                    st_next.recv_par = st.recv_par ^ it.line_in;
                    st_next.rx_shift[data_off[2:0]] = it.line_in;
                end
                else if (st.pos == sebx_pkg::POS_PARITY)
                begin
                    if (st.recv_par != it.line_in)
                        st_next.local_par_flag = 1'b1;
                end
                else if (st.pos == sebx_pkg::POS_REPORT)
                begin
                    if (it.line_in)
                        st_next.remote_par_flag = 1'b1;
                end
                else if (st.pos == sebx_pkg::POS_STOP)
                begin
                    if (it.line_in)
                        st_next.frame_flag = 1'b1;
                    if (!st_next.frame_flag && !st.local_par_flag && st.rx_shift != '0)
                    begin
                        res.rx_valid = 1'b1;
                        res.rx_byte  = st.rx_shift;
                    end
                end
                else
                begin
                    // idle: hold everything
                end
            end
            sebx_pkg::CMD_DRIVE:
            begin
                // restart the frame after stop or after a long clock gap
                if (it.gap_us > gap_thr || st.pos == sebx_pkg::POS_STOP)
                begin
                    pos_w                  = sebx_pkg::POS_IDLE;
                    st_next.recv_par       = 1'b0;
                    st_next.send_par       = 1'b0;
                    st_next.local_par_flag = 1'b0;
                    if (!st.remote_par_flag && !st.frame_flag)
                    begin
                        st_next.tx_hold = it.tx_byte;
                        res.tx_taken    = (it.tx_byte != '0);
                    end
                    else
                    begin
                        // repeat the held byte
                        st_next.remote_par_flag = 1'b0;
                        st_next.frame_flag      = 1'b0;
                    end
                end
                if (pos_w != sebx_pkg::POS_STOP)
                    pos_w = pos_w - 4'd1;
                drv_off = pos_w - sebx_pkg::POS_DATA_LO;
                priority if (pos_w == sebx_pkg::POS_START)
                    line = 1'b0;
                else if (pos_w >= sebx_pkg::POS_DATA_LO && pos_w <= sebx_pkg::POS_DATA_HI)
                begin
                    line             = st_next.tx_hold[drv_off[2:0]];
                    st_next.send_par = st_next.send_par ^ line;
                end
                else if (pos_w == sebx_pkg::POS_PARITY)
                    line = st_next.send_par;
                else if (pos_w == sebx_pkg::POS_REPORT)
                    line = st_next.local_par_flag;
                else
                    line = 1'b0;
                st_next.pos  = pos_w;
                res.line_out = line;
            end
            default:
            begin
            end
        endcase
        res.frame_fault  = st_next.frame_flag;
        res.parity_fault = st_next.local_par_flag;
        res.remote_fault = st_next.remote_par_flag;
    end

endmodule

// ----- src/sebx_state.sv -----
module sebx_state (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           upd_en,
    input  sebx_pkg::link_state_t          st_next,
    input  logic                           cfg_wr_en,
    input  logic [sebx_pkg::GAP_W-1:0]     cfg_wr_data,
    output sebx_pkg::link_state_t          st,
    output logic [sebx_pkg::GAP_W-1:0]     gap_thr
);

    sebx_pkg::link_state_t      st_reg;
    logic [sebx_pkg::GAP_W-1:0] gap_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg                 <= '{pos: sebx_pkg::POS_IDLE, default: '0};
            gap_thr_reg            <= sebx_pkg::GAP_RESET;
        end
        else
        begin
            if (upd_en)
                st_reg <= st_next;
            if (cfg_wr_en)
                gap_thr_reg <= cfg_wr_data;
        end
    end

    assign st      = st_reg;
    assign gap_thr = gap_thr_reg;

endmodule

// ----- src/clocked_serial_byte_exchange_slave_core.sv -----
// Channel  | Role   | Payload                                              | Accepted when
// ---------+--------+------------------------------------------------------+-----------------
// item     | sink   | cmd, line_in, gap_us, tx_byte                        | valid && ready
// result   | source | line_out, tx_taken, rx_valid, rx_byte, frame_fault,  | valid && ready
//          |        | parity_fault, remote_fault                           |
// cfg      | write  | cfg_wr_data = gap threshold in microseconds          | cfg_wr_en
//
// One item per cycle sustained while result.ready holds; an item moves from the input register
// into the result register (one pass of step logic) once the result register is free, and
// its result is then offered from the result register.
// The link state updates in the same cycle the item leaves the input register, so the
// next item always sees the state left by the previous one.
// Reset (rst_n low, asynchronous) empties both registers, parks the frame position at
// idle and loads the gap threshold with 1500.
// A stalled result holds the result register; the input register still takes one more
// item before item.ready drops.
module clocked_serial_byte_exchange_slave_core (
    input  logic                       clk,
    input  logic                       rst_n,
    sebx_item_if.sink                  item,
    sebx_result_if.source              result,
    input  logic                       cfg_wr_en,
    input  logic [sebx_pkg::GAP_W-1:0] cfg_wr_data
);

    // Input register
    logic                   in_valid_reg;
    sebx_pkg::item_t        in_reg;

    // Result register
    logic                   out_valid_reg;
    sebx_pkg::result_t      out_reg;

    sebx_pkg::link_state_t      st;
    sebx_pkg::link_state_t      st_next;
    sebx_pkg::result_t          step_res;
    logic [sebx_pkg::GAP_W-1:0] gap_thr;

    logic out_free;
    logic advance;
    logic take_item;

    // Advance the held item into the result register whenever that slot frees up
    assign out_free  = !out_valid_reg || result.ready;
    assign advance   = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || advance;
    assign take_item = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            in_reg.cmd     <= item.cmd;
            in_reg.line_in <= item.line_in;
            in_reg.gap_us  <= item.gap_us;
            in_reg.tx_byte <= item.tx_byte;
        end
        if (advance)
            out_reg <= step_res;
    end

    sebx_step u_step (
        .st      (st),
        .it      (in_reg),
        .gap_thr (gap_thr),
        .st_next (st_next),
        .res     (step_res)
    );

    // Commit the link state only when the item actually moves on
    sebx_state u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd_en      (advance),
        .st_next     (st_next),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .st          (st),
        .gap_thr     (gap_thr)
    );

    assign result.valid        = out_valid_reg;
    assign result.line_out     = out_reg.line_out;
    assign result.tx_taken     = out_reg.tx_taken;
    assign result.rx_valid     = out_reg.rx_valid;
    assign result.rx_byte      = out_reg.rx_byte;
    assign result.frame_fault  = out_reg.frame_fault;
    assign result.parity_fault = out_reg.parity_fault;
    assign result.remote_fault = out_reg.remote_fault;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        st.pos <= sebx_pkg::POS_IDLE)
        else $error("frame position beyond idle");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st))
        else $error("link state changed without an item");

    a_rx_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.rx_valid |->
            !out_reg.frame_fault && !out_reg.parity_fault && out_reg.rx_byte != '0)
        else $error("byte delivered from a faulty or empty frame");

    a_taken_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.tx_taken |-> !out_reg.line_out && !out_reg.rx_valid)
        else $error("byte taken outside a start bit");
`endif

endmodule
